[hdl/rvide_pkg.sv]
package rvide_pkg;

   localparam int XLEN = 32;

   localparam logic [2:0] CLS_LOAD   = 3'd0;
   localparam logic [2:0] CLS_MISC   = 3'd1;
   localparam logic [2:0] CLS_OPIMM  = 3'd2;
   localparam logic [2:0] CLS_JALR   = 3'd3;
   localparam logic [2:0] CLS_SYSTEM = 3'd4;

   // funct3 encodings, word bits 14..12
   localparam logic [2:0] F3_LB    = 3'd0;
   localparam logic [2:0] F3_LH    = 3'd1;
   localparam logic [2:0] F3_LW    = 3'd2;
   localparam logic [2:0] F3_LBU   = 3'd4;
   localparam logic [2:0] F3_LHU   = 3'd5;
   localparam logic [2:0] F3_FENCE = 3'd0;

   localparam logic [2:0] F3_ADDI  = 3'd0;
   localparam logic [2:0] F3_SLLI  = 3'd1;
   localparam logic [2:0] F3_SLTI  = 3'd2;
   localparam logic [2:0] F3_SLTIU = 3'd3;
   localparam logic [2:0] F3_XORI  = 3'd4;
   localparam logic [2:0] F3_SHR   = 3'd5;
   localparam logic [2:0] F3_ORI   = 3'd6;
   localparam logic [2:0] F3_ANDI  = 3'd7;

   localparam logic [6:0] F7_SRLI = 7'h00;
   localparam logic [6:0] F7_SRAI = 7'h20;

   localparam logic [11:0] IMM_ECALL  = 12'h000;
   localparam logic [11:0] IMM_EBREAK = 12'h001;

   localparam logic [4:0] REG_ZERO = 5'd0;

   typedef enum logic [4:0] {
      OP_ADDI    = 5'd0,
      OP_SLTI    = 5'd1,
      OP_SLTIU   = 5'd2,
      OP_XORI    = 5'd3,
      OP_ORI     = 5'd4,
      OP_ANDI    = 5'd5,
      OP_SLLI    = 5'd6,
      OP_SRLI    = 5'd7,
      OP_SRAI    = 5'd8,
      OP_JALR    = 5'd9,
      OP_LB      = 5'd10,
      OP_LH      = 5'd11,
      OP_LW      = 5'd12,
      OP_LBU     = 5'd13,
      OP_LHU     = 5'd14,
      OP_FENCE   = 5'd15,
      OP_ECALL   = 5'd16,
      OP_EBREAK  = 5'd17,
      OP_ILLEGAL = 5'd18
   } op_type;

   typedef struct packed {
      logic [2:0]      cmd;
      logic [XLEN-1:0] instr_word;
      logic [XLEN-1:0] rs1_value;
      logic [XLEN-1:0] pc_value;
   } item_type;

   typedef struct packed {
      op_type          op;
      logic [4:0]      rd;
      logic [XLEN-1:0] imm;
   } dec_type;

   typedef struct packed {
      op_type          operation;
      logic [4:0]      rd_index;
      logic            rd_write;
      logic [XLEN-1:0] rd_value;
      logic [XLEN-1:0] next_pc;
      logic [11:0]     immediate;
   } result_type;

endpackage

[hdl/rvide_decode.sv]
module rvide_decode (
   input  rvide_pkg::item_type item,
   output rvide_pkg::dec_type  dec
);

   logic [2:0]  funct3;
   logic [6:0]  funct7;
   logic [11:0] imm12;

   assign funct3 = item.instr_word[14:12];
   assign funct7 = item.instr_word[31:25];
   assign imm12  = item.instr_word[31:20];

   always_comb begin
      dec.rd  = item.instr_word[11:7];
      dec.imm = {{(rvide_pkg::XLEN-12){imm12[11]}}, imm12};
      dec.op  = rvide_pkg::OP_ILLEGAL;
      unique case (item.cmd)
         rvide_pkg::CLS_LOAD: begin
            unique case (funct3)
               rvide_pkg::F3_LB:  dec.op = rvide_pkg::OP_LB;
               rvide_pkg::F3_LH:  dec.op = rvide_pkg::OP_LH;
               rvide_pkg::F3_LW:  dec.op = rvide_pkg::OP_LW;
               rvide_pkg::F3_LBU: dec.op = rvide_pkg::OP_LBU;
               rvide_pkg::F3_LHU: dec.op = rvide_pkg::OP_LHU;
               default:           dec.op = rvide_pkg::OP_ILLEGAL;
            endcase
         end
         rvide_pkg::CLS_MISC: begin
            dec.op = (funct3 == rvide_pkg::F3_FENCE) ? rvide_pkg::OP_FENCE :
                                                       rvide_pkg::OP_ILLEGAL;
         end
         rvide_pkg::CLS_OPIMM: begin
            unique case (funct3)
               rvide_pkg::F3_ADDI:  dec.op = rvide_pkg::OP_ADDI;
               rvide_pkg::F3_SLLI:  dec.op = rvide_pkg::OP_SLLI;
               rvide_pkg::F3_SLTI:  dec.op = rvide_pkg::OP_SLTI;
               rvide_pkg::F3_SLTIU: dec.op = rvide_pkg::OP_SLTIU;
               rvide_pkg::F3_XORI:  dec.op = rvide_pkg::OP_XORI;
               rvide_pkg::F3_SHR: begin
                  if (funct7 == rvide_pkg::F7_SRLI) begin
                     dec.op = rvide_pkg::OP_SRLI;
                  end else if (funct7 == rvide_pkg::F7_SRAI) begin
                     dec.op = rvide_pkg::OP_SRAI;
                  end else begin
                     dec.op = rvide_pkg::OP_ILLEGAL;
                  end
               end
               rvide_pkg::F3_ORI:   dec.op = rvide_pkg::OP_ORI;
               rvide_pkg::F3_ANDI:  dec.op = rvide_pkg::OP_ANDI;
               default:             dec.op = rvide_pkg::OP_ILLEGAL;
            endcase
         end
         rvide_pkg::CLS_JALR: begin
            dec.op = rvide_pkg::OP_JALR;
         end
         rvide_pkg::CLS_SYSTEM: begin
            if (imm12 == rvide_pkg::IMM_ECALL) begin
               dec.op = rvide_pkg::OP_ECALL;
            end else if (imm12 == rvide_pkg::IMM_EBREAK) begin
               dec.op = rvide_pkg::OP_EBREAK;
            end else begin
               dec.op = rvide_pkg::OP_ILLEGAL;
            end
         end
         default: dec.op = rvide_pkg::OP_ILLEGAL;
      endcase
   end

endmodule

[hdl/rvide_execute.sv]
module rvide_execute (
   input  rvide_pkg::item_type   item,
   input  rvide_pkg::dec_type    dec,
   output rvide_pkg::result_type result
);

   logic [rvide_pkg::XLEN-1:0] rs1;
   logic [rvide_pkg::XLEN-1:0] imm;
   logic [rvide_pkg::XLEN-1:0] pc_plus4;
   logic [rvide_pkg::XLEN-1:0] sum;
   logic [rvide_pkg::XLEN-1:0] val;
   logic [4:0]                 shamt;
   logic                       writes;
   logic                       do_write;

   assign rs1      = item.rs1_value;
   assign imm      = dec.imm;
   assign shamt    = imm[4:0];
   assign pc_plus4 = item.pc_value + rvide_pkg::XLEN'(4);
   assign sum      = rs1 + imm;

   always_comb begin
      val    = '0;
      writes = 1'b1;
      unique case (dec.op)
         rvide_pkg::OP_ADDI:  val = sum;
         rvide_pkg::OP_SLTI:  val = rvide_pkg::XLEN'($signed(rs1) < $signed(imm));
         rvide_pkg::OP_SLTIU: val = rvide_pkg::XLEN'(rs1 < imm);
         rvide_pkg::OP_XORI:  val = rs1 ^ imm;
         rvide_pkg::OP_ORI:   val = rs1 | imm;
         rvide_pkg::OP_ANDI:  val = rs1 & imm;
         rvide_pkg::OP_SLLI:  val = rs1 << shamt;
         rvide_pkg::OP_SRLI:  val = rs1 >> shamt;
         rvide_pkg::OP_SRAI:  val = $unsigned($signed(rs1) >>> shamt);
         rvide_pkg::OP_JALR:  val = pc_plus4;
         default:             writes = 1'b0;
      endcase
   end

   assign do_write = writes && (dec.rd != rvide_pkg::REG_ZERO);

   assign result.operation = dec.op;
   assign result.rd_index  = dec.rd;
   assign result.rd_write  = do_write;
   assign result.rd_value  = do_write ? val : '0;
   assign result.next_pc   = (dec.op == rvide_pkg::OP_JALR) ?
                             {sum[rvide_pkg::XLEN-1:1], 1'b0} : pc_plus4;
   assign result.immediate = imm[11:0];

endmodule

[hdl/rv32i_itype_decode_execute_unit.sv]
// An item taken into the input register passes through decode and the ALU, which sit
// between the two registers, into the result register once that is free to take it.
// Throughput: one item per cycle while rsp_tready does not stall the result register.
// Either register refills in the same cycle it drains, so a stall only fills them.
// Reset (synchronous, active high) clears both valid flags; payload is not reset.
module rv32i_itype_decode_execute_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,  // instr_word, rs1_value, pc_value
   input  logic [2:0]  req_tuser,  // cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [87:0] rsp_tdata,  // rd_index, rd_write, rd_value, next_pc, immediate, zero pad
   output logic [4:0]  rsp_tuser   // operation
);

   rvide_pkg::item_type   item_ff, item_in;
   logic                  item_valid_ff, item_valid_in;
   rvide_pkg::result_type result_ff, result_in;
   logic                  result_valid_ff, result_valid_in;
   rvide_pkg::dec_type    dec;
   logic                  result_ready;
   logic                  advance;

   assign result_ready = !result_valid_ff || rsp_tready;
   assign advance      = item_valid_ff && result_ready;
   assign req_tready   = !item_valid_ff || result_ready;

   rvide_decode u_decode (
      .item (item_ff),
      .dec  (dec)
   );

   rvide_execute u_execute (
      .item   (item_ff),
      .dec    (dec),
      .result (result_in)
   );

   always_comb begin
      item_in.cmd        = req_tuser;
      item_in.instr_word = req_tdata[31:0];
      item_in.rs1_value  = req_tdata[63:32];
      item_in.pc_value   = req_tdata[95:64];
      item_valid_in      = item_valid_ff;
      if (req_tready) begin
         item_valid_in = req_tvalid;
      end
      result_valid_in = result_valid_ff;
      if (result_ready) begin
         result_valid_in = advance;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff   <= 1'b0;
         result_valid_ff <= 1'b0;
      end else begin
         item_valid_ff   <= item_valid_in;
         result_valid_ff <= result_valid_in;
      end
      if (req_tready && req_tvalid) begin
         item_ff <= item_in;
      end
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_tvalid = result_valid_ff;
   assign rsp_tuser  = result_ff.operation;
   assign rsp_tdata  = {6'd0,
                        result_ff.immediate,
                        result_ff.next_pc,
                        result_ff.rd_value,
                        result_ff.rd_write,
                        result_ff.rd_index};

endmodule
